### rtl/core/cal_pkg.sv
// shared types, constants and calendar helper functions for the calendar clock
// depends on nothing; imported by cal_update and calendar_clock_with_weekday
package cal_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned WdayW   = 3;

  localparam logic [YearW-1:0]   YearMin     = YearW'(1);
  localparam logic [YearW-1:0]   YearMax     = YearW'(9999);
  localparam logic [YearW-1:0]   YearReset   = YearW'(1970);
  localparam logic [MonthW-1:0]  MonthFirst  = MonthW'(1);
  localparam logic [MonthW-1:0]  MonthLast   = MonthW'(12);
  localparam logic [MonthW-1:0]  MonthMarch  = MonthW'(3);
  localparam logic [DayW-1:0]    DayFirst    = DayW'(1);
  localparam logic [HourW-1:0]   HourLast    = HourW'(23);
  localparam logic [MinuteW-1:0] MinuteLast  = MinuteW'(59);
  localparam logic [SecondW-1:0] SecondLast  = SecondW'(59);

  // tuser codes on the input side
  localparam logic KindTick = 1'b0;
  localparam logic KindSet  = 1'b1;

  // reciprocal constants: y / 100 = (y * 5243) >> 19, s / 7 = (s * 18725) >> 17,
  // exact for every 14-bit value
  localparam int unsigned Rcp100W   = 13;
  localparam int unsigned Rcp100Sh  = 19;
  localparam logic [Rcp100W-1:0] Rcp100 = Rcp100W'(5243);
  localparam int unsigned Rcp7W     = 15;
  localparam int unsigned Rcp7Sh    = 17;
  localparam logic [Rcp7W-1:0] Rcp7 = Rcp7W'(18725);
  localparam int unsigned Quot100W  = 8;
  localparam int unsigned Quot7W    = 12;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } cal_time_t;

  // quotient of a 14-bit value by 100
  function automatic logic [Quot100W-1:0] div100(input logic [YearW-1:0] y);
    logic [YearW+Rcp100W-1:0] prod;
    prod = {{Rcp100W{1'b0}}, y} * {{YearW{1'b0}}, Rcp100};
    return prod[Rcp100Sh +: Quot100W];
  endfunction

  // days in month m of a year; zero for a month code out of range
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                  input logic is_leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                     len = DayW'(30);
      4'd2:    len = is_leap ? DayW'(29) : DayW'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

  // per-month offset of the weekday formula
  function automatic logic [WdayW-1:0] week_offset(input logic [MonthW-1:0] m);
    logic [WdayW-1:0] off;
    unique case (m)
      4'd1, 4'd5:  off = WdayW'(0);
      4'd2, 4'd6:  off = WdayW'(3);
      4'd3, 4'd11: off = WdayW'(2);
      4'd4, 4'd7:  off = WdayW'(5);
      4'd8:        off = WdayW'(1);
      4'd9, 4'd12: off = WdayW'(4);
      4'd10:       off = WdayW'(6);
      default:     off = WdayW'(0);
    endcase
    return off;
  endfunction

endpackage

### rtl/core/cal_update.sv
// next-state logic of the calendar clock: one-second advance or checked load
// depends on cal_pkg
module cal_update import cal_pkg::*; (
  input  cal_time_t cur_i,
  input  logic      kind_i,
  input  cal_time_t set_i,
  output cal_time_t next_o,
  output logic      rejected_o
);

  logic [YearW-1:0]    year_sel;
  logic [Quot100W-1:0] q100;
  logic                div4, div100_hit, is_leap;
  logic [DayW-1:0]     mdays_cur, mdays_set;
  logic                set_ok;
  cal_time_t           tick_next;

  // one leap unit, shared between the load check and the advance
  assign year_sel   = (kind_i == KindSet) ? set_i.year : cur_i.year;
  assign q100       = div100(year_sel);
  assign div4       = (year_sel[1:0] == 2'b00);
  assign div100_hit = (year_sel == ({{(YearW-Quot100W){1'b0}}, q100} * YearW'(100)));
  assign is_leap    = (div4 && !div100_hit) || (div100_hit && (q100[1:0] == 2'b00));
  assign mdays_cur  = month_days(cur_i.month, is_leap);
  assign mdays_set  = month_days(set_i.month, is_leap);

  assign set_ok = (set_i.year >= YearMin) && (set_i.year <= YearMax) &&
                  (set_i.month >= MonthFirst) && (set_i.month <= MonthLast) &&
                  (set_i.day >= DayFirst) && (set_i.day <= mdays_set) &&
                  (set_i.hour <= HourLast) && (set_i.minute <= MinuteLast) &&
                  (set_i.second <= SecondLast);

  // carry chain of a one-second advance
  always_comb begin
    tick_next = cur_i;
    if (cur_i.second != SecondLast) begin
      tick_next.second = cur_i.second + SecondW'(1);
    end else begin
      tick_next.second = '0;
      if (cur_i.minute != MinuteLast) begin
        tick_next.minute = cur_i.minute + MinuteW'(1);
      end else begin
        tick_next.minute = '0;
        if (cur_i.hour != HourLast) begin
          tick_next.hour = cur_i.hour + HourW'(1);
        end else begin
          tick_next.hour = '0;
          if (cur_i.day < mdays_cur) begin
            tick_next.day = cur_i.day + DayW'(1);
          end else begin
            tick_next.day = DayFirst;
            if (cur_i.month < MonthLast) begin
              tick_next.month = cur_i.month + MonthW'(1);
            end else begin
              tick_next.month = MonthFirst;
              tick_next.year  = (cur_i.year >= YearMax) ? YearMin
                                                        : cur_i.year + YearW'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    rejected_o = 1'b0;
    next_o     = cur_i;
    if (kind_i == KindTick) begin
      next_o = tick_next;
    end else if (set_ok) begin
      next_o = set_i;
    end else begin
      rejected_o = 1'b1;
    end
  end

endmodule

### rtl/core/calendar_clock_with_weekday.sv
// gregorian calendar clock: takes a beat per cycle while s_axis_tready is high;
// the result passes three register stages; one beat per clock while not stalled
// the clock state is updated at the accepting edge, so back-to-back beats chain
// the weekday is computed in two stages behind it (divide by 100, then modulo 7)
// reset: 1 january 1970 00:00:00, pipeline empty; rst_ni is asynchronous, active low
// depends on cal_pkg and cal_update
module calendar_clock_with_weekday import cal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // new_year[13:0], new_month[17:14], new_day[22:18], new_hour[27:23],
  // new_minute[33:28], new_second[39:34]
  input  logic [39:0] s_axis_tdata,
  // kind: 0 tick, 1 set
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cur_year[13:0], cur_month[17:14], cur_day[22:18], cur_hour[27:23],
  // cur_minute[33:28], cur_second[39:34], week_day[42:40], zero[47:43]
  output logic [47:0] m_axis_tdata,
  // set_rejected
  output logic        m_axis_tuser
);

  localparam int unsigned SumW = YearW;

  // clock state
  cal_time_t state_q, state_d;
  cal_time_t set_fields;
  logic      rejected;

  // stage 1: snapshot of the state after the beat
  logic      s1_v_q;
  cal_time_t s1_time_q;
  logic      s1_rej_q;

  // stage 2: weekday sum before reduction
  logic            s2_v_q;
  cal_time_t       s2_time_q;
  logic            s2_rej_q;
  logic [SumW-1:0] s2_sum_q;

  // output register
  logic             m_v_q;
  cal_time_t        out_time_q;
  logic [WdayW-1:0] out_wd_q;
  logic             out_rej_q;

  logic out_rdy, s2_rdy, s1_rdy, in_acc;

  // weekday datapath
  logic [YearW-1:0]     yy;
  logic [Quot100W-1:0]  yy_q100;
  logic [SumW:0]        sum_wide;
  logic [SumW+Rcp7W-1:0] prod7;
  logic [Quot7W-1:0]    q7;
  logic [SumW-1:0]      rem7;

  // handshake: each stage takes new data when empty or when it drains
  assign out_rdy       = !m_v_q || m_axis_tready;
  assign s2_rdy        = !s2_v_q || out_rdy;
  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;
  assign in_acc        = s_axis_tvalid && s1_rdy;

  assign set_fields.year   = s_axis_tdata[13:0];
  assign set_fields.month  = s_axis_tdata[17:14];
  assign set_fields.day    = s_axis_tdata[22:18];
  assign set_fields.hour   = s_axis_tdata[27:23];
  assign set_fields.minute = s_axis_tdata[33:28];
  assign set_fields.second = s_axis_tdata[39:34];

  cal_update u_update (
    .cur_i      (state_q),
    .kind_i     (s_axis_tuser),
    .set_i      (set_fields),
    .next_o     (state_d),
    .rejected_o (rejected)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.year   <= YearReset;
      state_q.month  <= MonthFirst;
      state_q.day    <= DayFirst;
      state_q.hour   <= '0;
      state_q.minute <= '0;
      state_q.second <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // january and february count toward the previous year; state year is never 0
  assign yy       = (s1_time_q.month < MonthMarch) ? s1_time_q.year - YearW'(1)
                                                   : s1_time_q.year;
  assign yy_q100  = div100(yy);
  assign sum_wide = (SumW+1)'(yy) + (SumW+1)'(yy >> 2) - (SumW+1)'(yy_q100)
                  + (SumW+1)'(yy_q100 >> 2) + (SumW+1)'(week_offset(s1_time_q.month))
                  + (SumW+1)'(s1_time_q.day);

  // modulo 7 by reciprocal multiply
  assign prod7 = {{Rcp7W{1'b0}}, s2_sum_q} * {{SumW{1'b0}}, Rcp7};
  assign q7    = prod7[Rcp7Sh +: Quot7W];
  assign rem7  = s2_sum_q - ({{(SumW-Quot7W){1'b0}}, q7} * SumW'(7));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= s_axis_tvalid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (out_rdy) m_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_time_q <= state_d;
      s1_rej_q  <= rejected;
    end
    if (s2_rdy && s1_v_q) begin
      s2_time_q <= s1_time_q;
      s2_rej_q  <= s1_rej_q;
      s2_sum_q  <= sum_wide[SumW-1:0];
    end
    if (out_rdy && s2_v_q) begin
      out_time_q <= s2_time_q;
      out_rej_q  <= s2_rej_q;
      out_wd_q   <= rem7[WdayW-1:0];
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tuser  = out_rej_q;
  assign m_axis_tdata  = {5'b0, out_wd_q, out_time_q.second, out_time_q.minute,
                          out_time_q.hour, out_time_q.day, out_time_q.month,
                          out_time_q.year};

`ifndef SYNTHESIS
  // time of day stays in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.second <= SecondLast) && (state_q.minute <= MinuteLast) &&
    (state_q.hour <= HourLast))
    else $error("clock time out of range");

  // date stays in range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.month >= MonthFirst) && (state_q.month <= MonthLast) &&
    (state_q.day >= DayFirst) && (state_q.year >= YearMin) && (state_q.year <= YearMax))
    else $error("calendar date out of range");

  // a tick never produces a rejection flag
  a_tick_no_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == KindTick)) |=> !s1_rej_q)
    else $error("rejection flagged on a tick");

  // a rejected set leaves the clock state untouched
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rejected) |=> $stable(state_q))
    else $error("rejected set changed the clock state");

  // weekday leaving the block is a real day
  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_v_q |-> (out_wd_q <= WdayW'(6)))
    else $error("weekday out of range");
`endif

endmodule
